/* hdl/shsr_pkg.sv */
`timescale 1ns / 1ps

package shsr_pkg;

	// input item operation codes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_EDGE  = 2'd2;
	localparam logic [1:0] OP_DONE  = 2'd3;

	// read cycle phases
	localparam logic [1:0] PH_END   = 2'd0;
	localparam logic [1:0] PH_IDLE  = 2'd1;
	localparam logic [1:0] PH_START = 2'd2;
	localparam logic [1:0] PH_WAIT  = 2'd3;

	// read status codes
	localparam logic [1:0] ST_UNKNOWN = 2'd0;
	localparam logic [1:0] ST_OK      = 2'd1;
	localparam logic [1:0] ST_BAD     = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_BIT_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_MIN_EDGES     = 2'd1;
	localparam logic [1:0] REG_IDLE_WAIT_MS  = 2'd2;
	localparam logic [1:0] REG_START_LOW_MS  = 2'd3;

	// register reset values
	localparam logic [7:0]  RST_BIT_THRESHOLD = 8'd110;
	localparam logic [5:0]  RST_MIN_EDGES     = 6'd42;
	localparam logic [10:0] RST_IDLE_WAIT_MS  = 11'd1000;
	localparam logic [3:0]  RST_START_LOW_MS  = 4'd3;

	// edge decoding
	localparam int          DEF_EDGE_CAPACITY = 47;
	localparam logic [5:0]  FIRST_BIT_EDGE    = 6'd2;
	localparam logic [5:0]  LAST_BIT_EDGE     = 6'd41;
	localparam logic [10:0] MS_MAX            = 11'd2047;

endpackage

/* hdl/single_wire_humidity_sensor_reader_unit.sv */
`timescale 1ns / 1ps

// channel  signals                                  direction
// -------  ---------------------------------------  ---------
// in       in_valid, in_stall, op, pulse_width      item in
// out      out_valid, out_stall, line_low,          item out
//          capturing, status, finished, sensor_data
// cfg      cfg_wr_en, cfg_idx, cfg_wdata            register write
//
// one item per cycle unless stalled; each item's result is out the next cycle.
// the read cycle state updates at the accepting edge, the result register
// holds the outputs computed from the updated state.
// arst_n sets state, config and out_valid to defaults; the block comes up ended.
// in_stall follows out_stall while a result is held, so no item is lost.
module single_wire_humidity_sensor_reader_unit import shsr_pkg::*; #(
	parameter int EDGE_CAPACITY = DEF_EDGE_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  pulse_width,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        line_low,
	output logic        capturing,
	output logic [1:0]  status,
	output logic        finished,
	output logic [31:0] sensor_data,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_idx,
	input  logic [10:0] cfg_wdata
);

	localparam logic [5:0] EDGE_CAP = 6'(EDGE_CAPACITY);

	logic [7:0]  bit_threshold_q;
	logic [5:0]  min_edges_q;
	logic [10:0] idle_wait_ms_q;
	logic [3:0]  start_low_ms_q;

	logic [1:0]  phase_q, phase_d;
	logic [10:0] ms_count_q, ms_count_d, ms_inc;
	logic [5:0]  edge_count_q, edge_count_d;
	logic [39:0] bit_shift_q, bit_shift_d;
	logic        retry_used_q, retry_used_d;
	logic [1:0]  read_status_q, read_status_d;
	logic [31:0] data_word_q, data_word_d;

	logic        in_accept;
	logic        frame_enough;
	logic        sum_match;
	logic [7:0]  byte_sum;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_threshold_q <= RST_BIT_THRESHOLD;
			min_edges_q     <= RST_MIN_EDGES;
			idle_wait_ms_q  <= RST_IDLE_WAIT_MS;
			start_low_ms_q  <= RST_START_LOW_MS;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				REG_BIT_THRESHOLD: bit_threshold_q <= cfg_wdata[7:0];
				REG_MIN_EDGES:     min_edges_q     <= cfg_wdata[5:0];
				REG_IDLE_WAIT_MS:  idle_wait_ms_q  <= cfg_wdata;
				REG_START_LOW_MS:  start_low_ms_q  <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// handshake: take an item when the result register is free or draining
	assign in_stall  = out_valid && out_stall;
	assign in_accept = in_valid && !in_stall;

	// saturating millisecond count and frame checksum
	assign ms_inc   = (ms_count_q != MS_MAX) ? ms_count_q + 11'd1 : ms_count_q;
	assign byte_sum = bit_shift_q[39:32] + bit_shift_q[31:24]
	                + bit_shift_q[23:16] + bit_shift_q[15:8];
	assign frame_enough = edge_count_q >= min_edges_q;
	assign sum_match    = byte_sum == bit_shift_q[7:0];

	// next state of the read cycle
	always_comb begin
		phase_d       = phase_q;
		ms_count_d    = ms_count_q;
		edge_count_d  = edge_count_q;
		bit_shift_d   = bit_shift_q;
		retry_used_d  = retry_used_q;
		read_status_d = read_status_q;
		data_word_d   = data_word_q;
		case (op)
			OP_START: begin
				phase_d       = PH_IDLE;
				ms_count_d    = '0;
				edge_count_d  = '0;
				retry_used_d  = 1'b0;
				read_status_d = ST_UNKNOWN;
			end
			OP_TICK: begin
				ms_count_d = ms_inc;
				if (phase_q == PH_IDLE) begin
					if (ms_inc > idle_wait_ms_q) begin
						phase_d       = PH_START;
						ms_count_d    = '0;
						read_status_d = ST_UNKNOWN;
					end
				end else if (phase_q == PH_START) begin
					if (ms_inc >= {7'd0, start_low_ms_q}) begin
						phase_d      = PH_WAIT;
						edge_count_d = '0;
						bit_shift_d  = '0;
					end
				end
			end
			OP_EDGE: begin
				if (phase_q == PH_WAIT && edge_count_q < EDGE_CAP) begin
					if (edge_count_q >= FIRST_BIT_EDGE && edge_count_q <= LAST_BIT_EDGE)
						bit_shift_d = {bit_shift_q[38:0], pulse_width > bit_threshold_q};
					edge_count_d = edge_count_q + 6'd1;
				end
			end
			OP_DONE: begin
				if (phase_q == PH_WAIT) begin
					read_status_d = ST_BAD;
					if (frame_enough)
						data_word_d = bit_shift_q[39:8];
					if (frame_enough && sum_match) begin
						read_status_d = ST_OK;
						phase_d       = PH_END;
					end else if (!retry_used_q) begin
						retry_used_d = 1'b1;
						ms_count_d   = '0;
						phase_d      = PH_IDLE;
					end else begin
						phase_d = PH_END;
					end
				end
			end
			default: ;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_END;
			ms_count_q    <= '0;
			edge_count_q  <= '0;
			bit_shift_q   <= '0;
			retry_used_q  <= 1'b0;
			read_status_q <= ST_UNKNOWN;
			data_word_q   <= '0;
		end else if (in_accept) begin
			phase_q       <= phase_d;
			ms_count_q    <= ms_count_d;
			edge_count_q  <= edge_count_d;
			bit_shift_q   <= bit_shift_d;
			retry_used_q  <= retry_used_d;
			read_status_q <= read_status_d;
			data_word_q   <= data_word_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (in_accept)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			line_low    <= phase_d == PH_START;
			capturing   <= phase_d == PH_WAIT;
			status      <= read_status_d;
			finished    <= phase_d == PH_END;
			sensor_data <= data_word_d;
		end
	end

	// at most one phase flag per result
	a_phase_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({line_low, capturing, finished}))
		else $error("more than one phase flag set");

	// a good read always ends the cycle
	a_ok_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> finished)
		else $error("ok status outside the end phase");

	// a start request gives an unknown, unfinished result
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && op == OP_START |=> out_valid && status == ST_UNKNOWN && !finished)
		else $error("start request did not restart the cycle");

	// edge count stays within capacity
	a_edge_cap: assert property (@(posedge clk) disable iff (!arst_n)
		edge_count_q <= EDGE_CAP)
		else $error("edge count beyond capacity");

endmodule
